FILE: src/jsu_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the JSON string unescaper.
// No dependencies; all files but jsu_text_if.sv import this package.
package jsu_pkg;

	// Depth of the queue between the parser and the result sequencer
	localparam int QUEUE_DEPTH_DEF = 4;

	// At most this many result words follow from one text byte
	localparam int MAX_RES   = 5;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	// Parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_ESC,
		PH_HEX1,
		PH_AFTER_HIGH,
		PH_HIGH_BSL,
		PH_HEX2,
		PH_DROP
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
	localparam logic [2:0] ERR_UNTERM     = 3'd2;
	localparam logic [2:0] ERR_ESC_END    = 3'd3;
	localparam logic [2:0] ERR_TRUNC_U    = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd5;
	localparam logic [2:0] ERR_BAD_ESCAPE = 3'd6;

	// Characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_U     = 8'h75;

	// Surrogate bounds and the prefix of a high surrogate
	localparam logic [15:0] HIGH_MIN = 16'hD800;
	localparam logic [15:0] HIGH_MAX = 16'hDBFF;
	localparam logic [15:0] LOW_MIN  = 16'hDC00;
	localparam logic [15:0] LOW_MAX  = 16'hDFFF;
	localparam logic [5:0]  HIGH_TAG = 6'b110110;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// UTF-8 length limits
	localparam logic [20:0] UTF8_1_MAX = 21'h7F;
	localparam logic [20:0] UTF8_2_MAX = 21'h7FF;
	localparam logic [20:0] UTF8_3_MAX = 21'hFFFF;

	// What one text byte causes: an optional code point (sent as UTF-8),
	// an optional plain byte, then an optional close or error word
	typedef struct packed {
		logic        cp_vld;
		logic [20:0] cp;
		logic        data_vld;
		logic [7:0]  data;
		logic        tail_vld;
		kind_t       tail_kind;
		logic [2:0]  tail_code;
	} desc_t;

	// One result word
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic [2:0] code;
	} res_t;

endpackage

FILE: src/jsu_text_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the unescaper: text bytes in, result words out.
// No dependencies.
interface jsu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_last;

	modport source (output valid, output in_byte, output text_last, input ready);
	modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

interface jsu_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [2:0] error_code;
	logic       item_last;

	modport source (output valid, output out_byte, output kind, output error_code,
		output item_last, input ready);
	modport sink   (input valid, input out_byte, input kind, input error_code,
		input item_last, output ready);
endinterface

FILE: src/jsu_front.sv
`timescale 1ns / 1ps
// Parser front: takes a text byte a cycle unless q_full, tracks string and
// escape state and pushes a descriptor of its words. Depends on jsu_pkg.
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          text_last,
	input  logic          q_full,
	output logic          push,
	output jsu_pkg::desc_t desc
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_nxt;
	logic [15:0] acc_q, acc_nxt;
	logic [1:0]  dcnt_q, dcnt_nxt;
	logic        bad_q, bad_nxt;
	logic [9:0]  high_q, high_nxt;

	logic        accept;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] acc_shift;
	logic        bad_shift;
	logic [20:0] high_cp;

	// escape table lookup
	logic        esc_plain;
	logic [7:0]  esc_data;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the byte as a hex digit
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			hex_val = in_byte[3:0];
		end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hex_val = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_shift = {acc_q[11:0], hex_val};
	assign bad_shift = bad_q || !hex_ok;
	assign high_cp   = {5'd0, HIGH_TAG, high_q};

	// Map a simple escape letter to its byte
	always_comb begin
		esc_plain = 1'b1;
		esc_data  = in_byte;
		case (in_byte)
			CH_QUOTE: esc_data = CH_QUOTE;
			CH_BSL:   esc_data = CH_BSL;
			CH_SLASH: esc_data = CH_SLASH;
			CH_N:     esc_data = 8'h0A;
			CH_T:     esc_data = 8'h09;
			CH_R:     esc_data = 8'h0D;
			CH_B:     esc_data = 8'h08;
			CH_F:     esc_data = 8'h0C;
			default:  esc_plain = 1'b0;
		endcase
	end

	// Next state and descriptor
	always_comb begin
		phase_nxt = phase_q;
		acc_nxt   = acc_q;
		dcnt_nxt  = dcnt_q;
		bad_nxt   = bad_q;
		high_nxt  = high_q;
		desc      = '0;
		desc.tail_kind = KIND_ERROR;

		case (phase_q)
			PH_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					phase_nxt = PH_BODY;
				end else begin
					desc.tail_vld  = 1'b1;
					desc.tail_code = ERR_NO_QUOTE;
					phase_nxt      = PH_DROP;
				end
			end
			PH_HEX1, PH_HEX2: begin
				acc_nxt  = acc_shift;
				dcnt_nxt = dcnt_q + 2'd1;
				bad_nxt  = bad_shift;
				if (dcnt_q == 2'd3) begin
					if (bad_shift) begin
						desc.tail_vld  = 1'b1;
						desc.tail_code = ERR_BAD_HEX;
						phase_nxt      = PH_DROP;
					end else if (phase_q == PH_HEX1) begin
						if (acc_shift >= HIGH_MIN && acc_shift <= HIGH_MAX) begin
							high_nxt  = acc_shift[9:0];
							phase_nxt = PH_AFTER_HIGH;
						end else begin
							desc.cp_vld = 1'b1;
							desc.cp     = {5'd0, acc_shift};
							phase_nxt   = PH_BODY;
						end
					end else begin
						desc.cp_vld = 1'b1;
						if (acc_shift >= LOW_MIN && acc_shift <= LOW_MAX) begin
							desc.cp = SUPP_BASE + {1'b0, high_q, acc_shift[9:0]};
						end else begin
							desc.cp = high_cp;
						end
						phase_nxt = PH_BODY;
					end
				end
			end
			PH_AFTER_HIGH: begin
				if (in_byte == CH_BSL) begin
					phase_nxt = PH_HIGH_BSL;
				end else begin
					desc.cp_vld = 1'b1;
					desc.cp     = high_cp;
					phase_nxt   = PH_BODY;
				end
			end
			PH_HIGH_BSL: begin
				if (in_byte == CH_U) begin
					acc_nxt   = '0;
					dcnt_nxt  = '0;
					bad_nxt   = 1'b0;
					phase_nxt = PH_HEX2;
				end else begin
					desc.cp_vld = 1'b1;
					desc.cp     = high_cp;
					phase_nxt   = PH_ESC;
				end
			end
			default: begin
			end
		endcase

		// Body byte: from the string body, or after a held high surrogate
		if (phase_q == PH_BODY || (phase_q == PH_AFTER_HIGH && in_byte != CH_BSL)) begin
			if (in_byte == CH_QUOTE) begin
				desc.tail_vld  = 1'b1;
				desc.tail_kind = KIND_CLOSE;
				phase_nxt      = PH_DROP;
			end else if (in_byte == CH_BSL) begin
				phase_nxt = PH_ESC;
			end else begin
				desc.data_vld = 1'b1;
				desc.data     = in_byte;
				phase_nxt     = PH_BODY;
			end
		end

		// Escape letter: after a backslash, or after a high surrogate's backslash
		if (phase_q == PH_ESC || (phase_q == PH_HIGH_BSL && in_byte != CH_U)) begin
			if (esc_plain) begin
				desc.data_vld = 1'b1;
				desc.data     = esc_data;
				phase_nxt     = PH_BODY;
			end else if (in_byte == CH_U) begin
				acc_nxt   = '0;
				dcnt_nxt  = '0;
				bad_nxt   = 1'b0;
				phase_nxt = PH_HEX1;
			end else begin
				desc.tail_vld  = 1'b1;
				desc.tail_code = ERR_BAD_ESCAPE;
				phase_nxt      = PH_DROP;
			end
		end

		// End of text: flush a held surrogate, report where the text stopped
		if (text_last) begin
			case (phase_nxt)
				PH_BODY: begin
					desc.tail_vld  = 1'b1;
					desc.tail_code = ERR_UNTERM;
				end
				PH_ESC: begin
					desc.tail_vld  = 1'b1;
					desc.tail_code = ERR_ESC_END;
				end
				PH_HEX1, PH_HEX2: begin
					desc.tail_vld  = 1'b1;
					desc.tail_code = ERR_TRUNC_U;
				end
				PH_AFTER_HIGH: begin
					desc.cp_vld    = 1'b1;
					desc.cp        = {5'd0, HIGH_TAG, high_nxt};
					desc.tail_vld  = 1'b1;
					desc.tail_code = ERR_UNTERM;
				end
				PH_HIGH_BSL: begin
					desc.cp_vld    = 1'b1;
					desc.cp        = {5'd0, HIGH_TAG, high_nxt};
					desc.tail_vld  = 1'b1;
					desc.tail_code = ERR_ESC_END;
				end
				default: begin
				end
			endcase
			phase_nxt = PH_IDLE;
		end
	end

	assign push = accept && (desc.cp_vld || desc.data_vld || desc.tail_vld);

	// Hold parser state; advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			dcnt_q  <= '0;
			bad_q   <= 1'b0;
			high_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			acc_q   <= acc_nxt;
			dcnt_q  <= dcnt_nxt;
			bad_q   <= bad_nxt;
			high_q  <= high_nxt;
		end
	end

endmodule

FILE: src/jsu_queue.sv
`timescale 1ns / 1ps
// Short descriptor queue between parser front and result sequencer.
// Depends on jsu_pkg for the descriptor type.
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsu_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           head_vld,
	output jsu_pkg::desc_t head_desc
);
	import jsu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full      = (cnt_q == CNT_FULL);
	assign head_vld  = (cnt_q != '0);
	assign head_desc = mem_q[rd_ptr_q];
	assign do_pop    = pop && head_vld;

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/jsu_back.sv
`timescale 1ns / 1ps
// Result sequencer: expands a descriptor into UTF-8, data, close and error
// words, sent one per cycle while out_ready is high. Depends on jsu_pkg.
module jsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_vld,
	input  jsu_pkg::desc_t head_desc,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output jsu_pkg::res_t  out_res,
	output logic           out_last
);
	import jsu_pkg::*;

	res_t                 slot_q [MAX_RES];
	logic [RES_CNT_W-1:0] cnt_q;

	logic [7:0]           utf [4];
	logic [2:0]           ulen;
	logic [2:0]           cp_len;
	logic [2:0]           data_pos;
	logic [2:0]           tail_pos;
	res_t                 slot_new [MAX_RES];
	logic [RES_CNT_W-1:0] cnt_new;
	logic                 take;
	logic                 load;

	// Encode the code point as UTF-8
	always_comb begin
		logic [20:0] cp;
		cp  = head_desc.cp;
		utf[0] = cp[7:0];
		utf[1] = 8'h00;
		utf[2] = 8'h00;
		utf[3] = 8'h00;
		ulen   = 3'd1;
		if (cp <= UTF8_1_MAX) begin
			utf[0] = cp[7:0];
			ulen   = 3'd1;
		end else if (cp <= UTF8_2_MAX) begin
			utf[0] = {3'b110, cp[10:6]};
			utf[1] = {2'b10, cp[5:0]};
			ulen   = 3'd2;
		end else if (cp <= UTF8_3_MAX) begin
			utf[0] = {4'b1110, cp[15:12]};
			utf[1] = {2'b10, cp[11:6]};
			utf[2] = {2'b10, cp[5:0]};
			ulen   = 3'd3;
		end else begin
			utf[0] = {5'b11110, cp[20:18]};
			utf[1] = {2'b10, cp[17:12]};
			utf[2] = {2'b10, cp[11:6]};
			utf[3] = {2'b10, cp[5:0]};
			ulen   = 3'd4;
		end
	end

	assign cp_len   = head_desc.cp_vld ? ulen : 3'd0;
	assign data_pos = cp_len;
	assign tail_pos = cp_len + {2'd0, head_desc.data_vld};
	assign cnt_new  = RES_CNT_W'(tail_pos + {2'd0, head_desc.tail_vld});

	// Lay the words out in send order
	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			slot_new[i] = '{data: 8'h00, kind: KIND_DATA, code: ERR_NONE};
			if (3'(i) < cp_len) begin
				slot_new[i].data = utf[i[1:0]];
			end else if (3'(i) == data_pos && head_desc.data_vld) begin
				slot_new[i].data = head_desc.data;
			end else if (3'(i) == tail_pos && head_desc.tail_vld) begin
				slot_new[i].kind = head_desc.tail_kind;
				slot_new[i].code = (head_desc.tail_kind == KIND_ERROR) ?
					head_desc.tail_code : ERR_NONE;
			end
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_res   = slot_q[0];
	assign out_last  = (cnt_q == RES_CNT_W'(1));
	assign take      = out_valid && out_ready;
	assign load      = !out_valid || (take && out_last);
	assign pop       = load && head_vld;

	// Hold the word list; shift on each sent word, refill when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= head_vld ? cnt_new : '0;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot_q <= slot_new;
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

endmodule

FILE: src/json_string_unescaper.sv
`timescale 1ns / 1ps
// Top level of the JSON string unescaper: parser front, descriptor queue,
// result sequencer. Depends on jsu_pkg, jsu_text_if, jsu_res_if.
//
// Takes one text byte per cycle on the text channel while the queue has
// room and sends decoded words on the result channel. Each text byte is
// parsed in the cycle it is accepted; the words it causes (0 to 5) go into
// a descriptor queue of QUEUE_DEPTH entries, then into the sequencer's word
// list, and are sent one word per cycle while the result channel is ready.
// Throughput is one text byte per cycle while each byte yields at most one
// word and results are taken; a \u escape or surrogate pair that expands
// into several UTF-8 bytes holds the result port while they are sent, and
// the queue absorbs those bursts. The text channel drops ready only when
// the queue is full. No clearing pass after reset is needed.
module json_string_unescaper #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	jsu_text_if.sink  text,
	jsu_res_if.source result
);
	import jsu_pkg::*;

	desc_t push_desc;
	desc_t head_desc;
	logic  push;
	logic  q_full;
	logic  head_vld;
	logic  pop;
	res_t  res_word;
	logic  res_last;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_ready  (text.ready),
		.in_byte   (text.in_byte),
		.text_last (text.text_last),
		.q_full    (q_full),
		.push      (push),
		.desc      (push_desc)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.head_vld  (head_vld),
		.head_desc (head_desc)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head_desc (head_desc),
		.pop       (pop),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (res_word),
		.out_last  (res_last)
	);

	assign result.out_byte   = res_word.data;
	assign result.kind       = res_word.kind;
	assign result.error_code = res_word.code;
	assign result.item_last  = res_last;

endmodule

FILE: src/jsu_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the JSON string unescaper and their binding.
// Depends on jsu_pkg and the json_string_unescaper top level.
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_byte,
	input logic [1:0] res_kind,
	input logic [2:0] res_code,
	input logic       res_last
);
	import jsu_pkg::*;

	// A stalled result word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word withdrawn while stalled");

	// A stalled result word keeps its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_byte) && $stable(res_kind)
			&& $stable(res_code) && $stable(res_last))
		else $error("result payload changed while stalled");

	// Close and error words always end the group of their text byte
	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_CLOSE || res_kind == KIND_ERROR) |-> res_last)
		else $error("close or error word not last of its group");

	// Only error words carry a code, and always a nonzero one
	a_code_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_kind == KIND_ERROR) == (res_code != ERR_NONE)))
		else $error("error code does not match word kind");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_byte  (result.out_byte),
	.res_kind  (result.kind),
	.res_code  (result.error_code),
	.res_last  (result.item_last)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescaper: scoreboard class with its own
// decoder, valid/ready drivers with random idling. Depends on jsu_pkg and the
// jsu_text_if / jsu_res_if interfaces.
module testbench;
	import jsu_pkg::*;

	localparam int TEXT_ITEMS  = 460;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int HOLD_AT     = 150;
	localparam int STEADY_FROM = 250;
	localparam int STEADY_TO   = 350;
	localparam int DRAIN_AT    = 400;
	localparam int IDLE_PCT    = 38;

	// Kinds of string fragments for the random texts
	typedef enum int {
		FR_RAW,
		FR_SIMPLE,
		FR_BMP,
		FR_PAIR,
		FR_HIGH_RAW,
		FR_HIGH_ESC,
		FR_HIGH_NOT_LOW,
		FR_LONE_LOW,
		FR_BAD_HEX,
		FR_BAD_ESC
	} frag_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic [2:0] code;
		logic       item_end;
	} res_word_t;

	// Decoder copy plus the queue of words still owed by the block
	class unescape_scoreboard;
		phase_t      parse_ph  = PH_IDLE;
		logic [15:0] hex_acc   = '0;
		logic [2:0]  hex_cnt   = '0;
		bit          hex_bad   = 1'b0;
		logic [15:0] held_high = '0;
		res_word_t   expected_words[$];
		res_word_t   step_words[$];
		int          n_fail = 0;

		task report(string what);
			n_fail++;
			$display("MISMATCH: %s", what);
		endtask

		function void push_word(logic [7:0] d, kind_t k, logic [2:0] c);
			res_word_t w;
			if (step_words.size() >= MAX_RES)
				return;
			w.data     = d;
			w.kind     = k;
			w.code     = c;
			w.item_end = 1'b0;
			step_words.insert(step_words.size(), w);
		endfunction

		function void push_error(logic [2:0] c);
			push_word(8'h00, KIND_ERROR, c);
			parse_ph = PH_DROP;
		endfunction

		// Split a code point into UTF-8 bytes
		function void push_cp(logic [20:0] cp);
			if (cp <= UTF8_1_MAX) begin
				push_word(cp[7:0], KIND_DATA, ERR_NONE);
			end else if (cp <= UTF8_2_MAX) begin
				push_word({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
				push_word({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
			end else if (cp <= UTF8_3_MAX) begin
				push_word({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
				push_word({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
				push_word({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
			end else begin
				push_word({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
				push_word({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
				push_word({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
				push_word({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
			end
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39)
				return int'(c - 8'h30);
			if (c >= 8'h61 && c <= 8'h66)
				return int'(c - 8'h61) + 10;
			if (c >= 8'h41 && c <= 8'h46)
				return int'(c - 8'h41) + 10;
			return -1;
		endfunction

		function void body_char(logic [7:0] c);
			if (c == CH_QUOTE) begin
				push_word(8'h00, KIND_CLOSE, ERR_NONE);
				parse_ph = PH_DROP;
			end else if (c == CH_BSL) begin
				parse_ph = PH_ESC;
			end else begin
				push_word(c, KIND_DATA, ERR_NONE);
			end
		endfunction

		function void begin_hex(phase_t nxt);
			hex_acc  = '0;
			hex_cnt  = '0;
			hex_bad  = 1'b0;
			parse_ph = nxt;
		endfunction

		function void escape_char(logic [7:0] c);
			logic [7:0] b;
			case (c)
				CH_QUOTE, CH_BSL, CH_SLASH: b = c;
				CH_N: b = 8'h0A;
				CH_T: b = 8'h09;
				CH_R: b = 8'h0D;
				CH_B: b = 8'h08;
				CH_F: b = 8'h0C;
				CH_U: begin
					begin_hex(PH_HEX1);
					return;
				end
				default: begin
					push_error(ERR_BAD_ESCAPE);
					return;
				end
			endcase
			push_word(b, KIND_DATA, ERR_NONE);
			parse_ph = PH_BODY;
		endfunction

		// Gather one hex digit; act on the fourth
		function void hex_char(logic [7:0] c);
			int v;
			v = hex_digit(c);
			if (v < 0) begin
				hex_bad = 1'b1;
				v = 0;
			end
			hex_acc = {hex_acc[11:0], v[3:0]};
			hex_cnt = hex_cnt + 3'd1;
			if (hex_cnt < 3'd4)
				return;
			if (hex_bad) begin
				push_error(ERR_BAD_HEX);
				return;
			end
			if (parse_ph == PH_HEX1) begin
				if (hex_acc >= HIGH_MIN && hex_acc <= HIGH_MAX) begin
					held_high = hex_acc;
					parse_ph  = PH_AFTER_HIGH;
					return;
				end
				push_cp({5'd0, hex_acc});
			end else if (hex_acc >= LOW_MIN && hex_acc <= LOW_MAX) begin
				push_cp(SUPP_BASE + {1'b0, held_high[9:0], hex_acc[9:0]});
			end else begin
				push_cp({5'd0, held_high});
			end
			parse_ph = PH_BODY;
		endfunction

		// Predict the words caused by one accepted text byte
		function void note_text(logic [7:0] c, logic fin);
			res_word_t w;
			step_words.delete();
			case (parse_ph)
				PH_IDLE: begin
					if (c == CH_QUOTE)
						parse_ph = PH_BODY;
					else
						push_error(ERR_NO_QUOTE);
				end
				PH_BODY: body_char(c);
				PH_ESC: escape_char(c);
				PH_HEX1, PH_HEX2: hex_char(c);
				PH_AFTER_HIGH: begin
					if (c == CH_BSL) begin
						parse_ph = PH_HIGH_BSL;
					end else begin
						push_cp({5'd0, held_high});
						parse_ph = PH_BODY;
						body_char(c);
					end
				end
				PH_HIGH_BSL: begin
					if (c == CH_U) begin
						begin_hex(PH_HEX2);
					end else begin
						push_cp({5'd0, held_high});
						escape_char(c);
					end
				end
				default: parse_ph = PH_DROP;
			endcase
			// End of text: flush a held surrogate, then flag where we stopped
			if (fin) begin
				case (parse_ph)
					PH_BODY: push_word(8'h00, KIND_ERROR, ERR_UNTERM);
					PH_ESC: push_word(8'h00, KIND_ERROR, ERR_ESC_END);
					PH_HEX1, PH_HEX2: push_word(8'h00, KIND_ERROR, ERR_TRUNC_U);
					PH_AFTER_HIGH: begin
						push_cp({5'd0, held_high});
						push_word(8'h00, KIND_ERROR, ERR_UNTERM);
					end
					PH_HIGH_BSL: begin
						push_cp({5'd0, held_high});
						push_word(8'h00, KIND_ERROR, ERR_ESC_END);
					end
					default: ;
				endcase
				parse_ph = PH_IDLE;
			end
			// Mark the final word of this byte and queue them all
			while (step_words.size() > 0) begin
				w = step_words.pop_front();
				w.item_end = (step_words.size() == 0);
				expected_words.insert(expected_words.size(), w);
			end
		endfunction

		task check_word(res_word_t got);
			res_word_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word data=%02h kind=%0d code=%0d end=%0b",
					got.data, got.kind, got.code, got.item_end));
				return;
			end
			want = expected_words.pop_front();
			if (got.data !== want.data)
				report($sformatf("out_byte %02h, want %02h", got.data, want.data));
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.code !== want.code)
				report($sformatf("error_code %0d, want %0d", got.code, want.code));
			if (got.item_end !== want.item_end)
				report($sformatf("item_last %0b, want %0b", got.item_end, want.item_end));
		endtask
	endclass

	logic clk;
	logic arst_n;
	jsu_text_if text_ch();
	jsu_res_if  res_ch();

	unescape_scoreboard sb;
	logic [7:0] text_bytes[$];
	int  n_sent    = 0;
	int  n_cycles  = 0;
	bit  idle_on   = 1'b1;
	bit  hold_req  = 1'b0;

	json_string_unescaper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels at the rising edge
	always @(posedge clk) begin
		res_word_t got;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready)
				sb.note_text(text_ch.in_byte, text_ch.text_last);
			if (res_ch.valid && res_ch.ready) begin
				got.data     = res_ch.out_byte;
				got.kind     = kind_t'(res_ch.kind);
				got.code     = res_ch.error_code;
				got.item_end = res_ch.item_last;
				sb.check_word(got);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					res_ch.ready = 1'b0;
					@(negedge clk);
				end
			end
			res_ch.ready = idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
		end
	end

	// Offer one text byte and hold it until taken; entered and left at a falling edge
	task send_text(logic [7:0] b, logic fin);
		if (n_sent == HOLD_AT)
			hold_req = 1'b1;
		idle_on = !(n_sent >= STEADY_FROM && n_sent < STEADY_TO);
		if (n_sent == DRAIN_AT) begin
			text_ch.valid = 1'b0;
			while (sb.expected_words.size() != 0)
				@(negedge clk);
		end
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			text_ch.valid     = 1'b0;
			text_ch.in_byte   = 8'($urandom_range(0, 255));
			text_ch.text_last = 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		text_ch.valid     = 1'b1;
		text_ch.in_byte   = b;
		text_ch.text_last = fin;
		do
			@(posedge clk);
		while (!text_ch.ready);
		n_sent++;
		@(negedge clk);
	endtask

	task send_bytes();
		for (int i = 0; i < text_bytes.size(); i++)
			send_text(text_bytes[i], i == text_bytes.size() - 1);
	endtask

	// Append one byte to the text being built
	function void add_byte(logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endfunction

	task push_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function logic [7:0] hex_char_of(logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	task push_u(logic [15:0] v);
		add_byte(CH_BSL);
		add_byte(CH_U);
		for (int i = 3; i >= 0; i--)
			add_byte(hex_char_of(v[i*4 +: 4]));
	endtask

	function logic [7:0] raw_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_QUOTE || b == CH_BSL);
		return b;
	endfunction

	function logic [7:0] simple_esc();
		logic [7:0] pick[8];
		pick = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_N, CH_T, CH_R, CH_B, CH_F};
		return pick[$urandom_range(0, 7)];
	endfunction

	function logic [7:0] bad_esc_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_N, CH_T, CH_R, CH_B, CH_F, CH_U});
		return b;
	endfunction

	function logic [15:0] high_val();
		return HIGH_MIN + 16'($urandom_range(0, 1023));
	endfunction

	function logic [15:0] low_val();
		return LOW_MIN + 16'($urandom_range(0, 1023));
	endfunction

	// Append one fragment of string content
	task push_frag(frag_t f);
		logic [15:0] v;
		logic [7:0]  b;
		int          pos;
		case (f)
			FR_RAW: add_byte(raw_char());
			FR_SIMPLE: begin
				add_byte(CH_BSL);
				add_byte(simple_esc());
			end
			FR_BMP: begin
				case ($urandom_range(0, 2))
					0: v = 16'($urandom_range(0, 127));
					1: v = 16'($urandom_range(128, 2047));
					default: v = 16'($urandom_range(0, 65535));
				endcase
				if (v >= HIGH_MIN && v <= LOW_MAX)
					v = v ^ 16'h4000;
				push_u(v);
			end
			FR_PAIR: begin
				push_u(high_val());
				push_u(low_val());
			end
			FR_HIGH_RAW: begin
				push_u(high_val());
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_BSL);
				add_byte(b);
			end
			FR_HIGH_ESC: begin
				push_u(high_val());
				add_byte(CH_BSL);
				add_byte($urandom_range(0, 3) ? simple_esc() : bad_esc_char());
			end
			FR_HIGH_NOT_LOW: begin
				push_u(high_val());
				do
					v = 16'($urandom_range(0, 65535));
				while (v >= LOW_MIN && v <= LOW_MAX);
				push_u(v);
			end
			FR_LONE_LOW: push_u(low_val());
			FR_BAD_HEX: begin
				push_u(16'($urandom_range(0, 65535)));
				do
					b = 8'($urandom_range(0, 255));
				while (sb.hex_digit(b) >= 0);
				pos = $urandom_range(0, 3);
				text_bytes[text_bytes.size() - 4 + pos] = b;
			end
			default: begin
				add_byte(CH_BSL);
				add_byte(bad_esc_char());
			end
		endcase
	endtask

	// Build one random text: mostly well-formed strings, some noise and cut-offs
	task make_text();
		int n;
		int keep;
		text_bytes.delete();
		if ($urandom_range(0, 99) < 8) begin
			n = $urandom_range(1, 4);
			repeat (n)
				add_byte(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 99) < 6)
			add_byte(raw_char());
		else
			add_byte(CH_QUOTE);
		n = $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(0, 2) == 0)
				push_frag(FR_RAW);
			else
				push_frag(frag_t'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 99) < 70) begin
			add_byte(CH_QUOTE);
			n = $urandom_range(0, 2);
			repeat (n)
				add_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 99) < 12) begin
			keep = $urandom_range(1, text_bytes.size());
			while (text_bytes.size() > keep)
				void'(text_bytes.pop_back());
		end
	endtask

	initial begin
		sb = new();
		arst_n            = 1'b0;
		text_ch.valid     = 1'b0;
		text_ch.in_byte   = 8'h00;
		text_ch.text_last = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: missing quote on a zero byte
		text_bytes.delete();
		add_byte(8'h00);
		send_bytes();
		// Directed: top raw byte, every short escape, largest pair, text ends after it
		text_bytes.delete();
		add_byte(CH_QUOTE);
		add_byte(8'hFF);
		push_str("\\\"\\\\\\/\\n\\t\\r\\b\\f");
		push_u(HIGH_MAX);
		push_u(LOW_MAX);
		send_bytes();

		// Random texts
		while (n_sent < TEXT_ITEMS) begin
			make_text();
			send_bytes();
		end
		text_ch.valid = 1'b0;

		// Wait out the remaining words, then a short tail
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.expected_words.size() != 0)
			sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));
		if (sb.n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
